### rtl/core/cdb_pkg.sv
// Shared types and constants for the circular deque buffer.
package cdb_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 255;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned MODE_W           = 2;
  localparam int unsigned CAP_W            = 8;
  localparam logic [CAP_W-1:0] CAP_RESET   = 8'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY      = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_PUSH_FRONT = 2'd2,
    MODE_POP_FRONT  = 2'd3
  } mode_t;

  // Flags of one step, from the pointer control to the result stage
  typedef struct packed {
    logic accepted;
    logic is_empty;
    logic is_full;
  } step_stat_t;

endpackage

### rtl/core/cdb_in_if.sv
// Request channel: action code and word to push.
interface cdb_in_if import cdb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

### rtl/core/cdb_out_if.sv
// Result channel: outcome flags and the front and back words.
interface cdb_out_if import cdb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, output accepted, output front_value, output back_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input back_value,
                  input is_empty, input is_full, output ready);
endinterface

### rtl/core/cdb_slot_ram.sv
// Slot store: one write port, two registered read ports, write-first forwarding.
module cdb_slot_ram import cdb_pkg::*; #(
  parameter int unsigned DEPTH = MAX_ELEMENTS_DEF + 1,
  parameter int unsigned AW    = $clog2(MAX_ELEMENTS_DEF + 1)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_front,
  input  logic [AW-1:0]     raddr_back,
  output logic [WORD_W-1:0] rdata_front,
  output logic [WORD_W-1:0] rdata_back
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_front_r;
  logic [WORD_W-1:0] rd_back_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // same-cycle write to a read address returns the new word
  always_ff @(posedge clk) begin
    if (re) begin
      rd_front_r <= (we && (waddr == raddr_front)) ? wdata : mem[raddr_front];
      rd_back_r  <= (we && (waddr == raddr_back))  ? wdata : mem[raddr_back];
    end
  end

  assign rdata_front = rd_front_r;
  assign rdata_back  = rd_back_r;

endmodule

### rtl/core/cdb_ptr_ctrl.sv
// Head/tail pointers, empty flag and ring size; drives the slot store ports.
module cdb_ptr_ctrl import cdb_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int unsigned PTR_W        = $clog2(MAX_ELEMENTS_DEF + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     fire,
  input  logic [MODE_W-1:0]        mode,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     mem_we,
  output logic [PTR_W-1:0]         mem_waddr,
  output logic [WORD_W-1:0]        mem_wdata,
  output logic                     mem_re,
  output logic [PTR_W-1:0]         mem_raddr_front,
  output logic [PTR_W-1:0]         mem_raddr_back,
  output step_stat_t               stat
);

  localparam int unsigned CW = (CAP_W > PTR_W) ? CAP_W : PTR_W;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [PTR_W-1:0] last_r;   // highest slot index = clamped capacity
  logic             full;
  logic             acc;
  logic             wr;
  mode_t            op;

  function automatic logic [PTR_W-1:0] clamp_last(input logic [CAP_W-1:0] c);
    logic [CW-1:0] ce;
    ce = CW'(c);
    if (ce == '0) begin
      ce = CW'(1);
    end else if (ce > CW'(MAX_ELEMENTS)) begin
      ce = CW'(MAX_ELEMENTS);
    end
    return ce[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
    return (p >= last) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W-1:0] last);
    return ((p == '0) || (p > last)) ? last : p - PTR_W'(1);
  endfunction

  assign op   = mode_t'(mode);
  assign full = (head_r == tail_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    acc       = 1'b0;
    wr        = 1'b0;
    mem_waddr = tail_r;
    unique case (op)
      MODE_PUSH_BACK: begin
        if (!full) begin
          wr        = 1'b1;
          mem_waddr = tail_r;
          tail_nxt  = ring_next(tail_r, last_r);
          empty_nxt = 1'b0;
          acc       = 1'b1;
        end
      end
      MODE_PUSH_FRONT: begin
        if (!full) begin
          wr        = 1'b1;
          mem_waddr = head_r;
          head_nxt  = ring_prev(head_r, last_r);
          empty_nxt = 1'b0;
          acc       = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (!empty_r) begin
          head_nxt = ring_next(head_r, last_r);
          if (ring_next(head_nxt, last_r) == tail_r) begin
            empty_nxt = 1'b1;
          end
          acc = 1'b1;
        end
      end
      MODE_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  assign mem_we          = fire && wr;
  assign mem_wdata       = push_value;
  assign mem_re          = fire;
  assign mem_raddr_front = ring_next(head_nxt, last_r);
  assign mem_raddr_back  = ring_prev(tail_nxt, last_r);

  assign stat.accepted = acc;
  assign stat.is_empty = empty_nxt;
  assign stat.is_full  = (head_nxt == tail_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= PTR_W'(1);
      empty_r <= 1'b1;
      last_r  <= clamp_last(CAP_RESET);
    end else if (cfg_we) begin
      // new capacity empties the ring
      head_r  <= '0;
      tail_r  <= PTR_W'(1);
      empty_r <= 1'b1;
      last_r  <= clamp_last(cfg_wdata);
    end else if (fire) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= last_r) && (tail_r <= last_r))
    else $error("pointer outside ring");

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty_r))
    else $error("ring flagged full and empty at once");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we && acc && (op == MODE_PUSH_BACK || op == MODE_PUSH_FRONT))
      |=> !empty_r)
    else $error("empty flag still set after a push");

  a_full_refuses: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we && full && (op == MODE_PUSH_BACK || op == MODE_PUSH_FRONT))
      |=> ($stable(head_r) && $stable(tail_r)))
    else $error("push moved a pointer while full");

endmodule

### rtl/core/circular_deque_buffer.sv
// Top level of the circular deque buffer: pointer control, slot store, result stage.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------------
//  in_if    | in  | valid / ready    | mode, push_value
//  out_if   | out | valid / ready    | accepted, front_value, back_value,
//           |     |                  | is_empty, is_full
//  cfg      | in  | cfg_we (no wait) | cfg_wdata = capacity
//
//  One item per cycle when the result side keeps up. A result passes the slot store read
//  register and then the output register before it shows on out_if. The registered
//  read of the slot store sets this path: the write and both reads of one item fall in
//  the same cycle, with write-first forwarding inside the store.
//  Reset (rst_n low, synchronous) empties the ring and sets capacity to 255; the
//  slot store itself is not cleared, so no clearing pass is needed.
//  A stalled out_if holds its result; in_if takes one more item behind it and then
//  drops ready until the output register frees.
module circular_deque_buffer import cdb_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  cdb_in_if.sink           in_if,
  cdb_out_if.source        out_if,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DEPTH = MAX_ELEMENTS + 1;

  logic              fire;
  logic              move;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr_front;
  logic [PTR_W-1:0]  mem_raddr_back;
  logic [WORD_W-1:0] rd_front;
  logic [WORD_W-1:0] rd_back;
  step_stat_t        stat;

  // read stage: flags wait here beside the store's read registers
  logic              pend_r;
  step_stat_t        stat_r;

  // output register
  logic                     out_valid_r;
  logic                     out_acc_r;
  logic signed [WORD_W-1:0] out_front_r;
  logic signed [WORD_W-1:0] out_back_r;
  logic                     out_empty_r;
  logic                     out_full_r;

  // read stage drains into the output register when that is free or being taken
  assign move         = pend_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !pend_r || move;
  assign fire         = in_if.valid && in_if.ready;

  cdb_ptr_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .PTR_W        (PTR_W)
  ) u_ptr_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fire            (fire),
    .mode            (in_if.mode),
    .push_value      (in_if.push_value),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr_front (mem_raddr_front),
    .mem_raddr_back  (mem_raddr_back),
    .stat            (stat)
  );

  cdb_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_slot_ram (
    .clk         (clk),
    .we          (mem_we),
    .waddr       (mem_waddr),
    .wdata       (mem_wdata),
    .re          (mem_re),
    .raddr_front (mem_raddr_front),
    .raddr_back  (mem_raddr_back),
    .rdata_front (rd_front),
    .rdata_back  (rd_back)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (fire) begin
      pend_r <= 1'b1;
    end else if (move) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stat_r <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // an empty ring reports zero words, never store contents
  always_ff @(posedge clk) begin
    if (move) begin
      out_acc_r   <= stat_r.accepted;
      out_empty_r <= stat_r.is_empty;
      out_full_r  <= stat_r.is_full;
      out_front_r <= stat_r.is_empty ? '0 : rd_front;
      out_back_r  <= stat_r.is_empty ? '0 : rd_back;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.accepted    = out_acc_r;
  assign out_if.front_value = out_front_r;
  assign out_if.back_value  = out_back_r;
  assign out_if.is_empty    = out_empty_r;
  assign out_if.is_full     = out_full_r;

  a_fire_pends: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> pend_r)
    else $error("accepted item not held in read stage");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("result lost between read stage and output register");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready)
      |=> (out_valid_r && $stable(out_front_r) && $stable(out_back_r)))
    else $error("stalled result changed or dropped");

endmodule
